### design/great_circle_distance_defines.svh
// assertion macros shared by the great-circle distance checker
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define GCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/gcd_pkg.sv
// shared constants, widths and arctangent table for the great-circle distance pipeline
package gcd_pkg;

  localparam int LAT_W    = 24;
  localparam int LON_W    = 25;
  localparam int DIST_W   = 23;
  localparam int ANG_W    = 31;  // unsigned q30 angle or unit value
  localparam int CW       = 34;  // cordic datapath, signed
  localparam int STAGES   = 32;  // cordic iterations
  localparam int SQ_STEPS = 31;  // root digits
  localparam int SQ_RAD_W = 2 * SQ_STEPS;
  localparam int SQ_REM_W = 35;

  localparam logic signed [LAT_W-1:0] LAT_MAX = 24'sd5898240;
  localparam logic signed [LAT_W-1:0] LAT_MIN = -24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_MAX = 25'sd11796480;
  localparam logic signed [LON_W-1:0] LON_MIN = -25'sd11796480;

  localparam logic [24:0]       DEG2RAD_Q30 = 25'd18740330;
  localparam logic [31:0]       HALF_PI_Q30 = 32'd1686629713;
  localparam logic [32:0]       PI_Q30      = 33'd3373259426;
  localparam logic [ANG_W-1:0]  Q30_ONE     = 31'h40000000;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [21:0]       TWO_R_Q8    = 22'd3261952;  // 2 * 6371 * 256
  localparam logic [DIST_W-1:0] HALF_CIRC_Q8 = 23'd5123863;

  // atan(2^-i) in q30
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sh03243F6A8;
      1:  v = 34'sh01DAC6705;
      2:  v = 34'sh00FADBAFC;
      3:  v = 34'sh007F56EA6;
      4:  v = 34'sh003FEAB76;
      5:  v = 34'sh001FFD55B;
      6:  v = 34'sh000FFFAAA;
      7:  v = 34'sh0007FFF55;
      8:  v = 34'sh0003FFFEA;
      9:  v = 34'sh0001FFFFD;
      10: v = 34'sh0000FFFFF;
      11: v = 34'sh00007FFFF;
      12: v = 34'sh00003FFFF;
      13: v = 34'sh00001FFFF;
      14: v = 34'sh00000FFFF;
      15: v = 34'sh000007FFF;
      16: v = 34'sh000003FFF;
      17: v = 34'sh000001FFF;
      18: v = 34'sh000000FFF;
      19: v = 34'sh0000007FF;
      20: v = 34'sh0000003FF;
      21: v = 34'sh0000001FF;
      22: v = 34'sh0000000FF;
      23: v = 34'sh00000007F;
      24: v = 34'sh00000003F;
      25: v = 34'sh00000001F;
      26: v = 34'sh00000000F;
      27: v = 34'sh000000008;
      28: v = 34'sh000000004;
      29: v = 34'sh000000002;
      30: v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/gcd_rot_cordic.sv
// four-lane pipelined rotation-mode cordic giving sine and cosine clamped to [0, 1]
module gcd_rot_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_in,
  input  logic [gcd_pkg::ANG_W-1:0]   ang [4],
  output logic                        valid_out,
  output logic [gcd_pkg::ANG_W-1:0]   sin_q30 [4],
  output logic [gcd_pkg::ANG_W-1:0]   cos_q30 [4]
);

  logic signed [gcd_pkg::CW-1:0] xr [gcd_pkg::STAGES][4];
  logic signed [gcd_pkg::CW-1:0] yr [gcd_pkg::STAGES][4];
  logic signed [gcd_pkg::CW-1:0] zr [gcd_pkg::STAGES][4];
  logic signed [gcd_pkg::CW-1:0] x_next [gcd_pkg::STAGES][4];
  logic signed [gcd_pkg::CW-1:0] y_next [gcd_pkg::STAGES][4];
  logic signed [gcd_pkg::CW-1:0] z_next [gcd_pkg::STAGES][4];
  logic [gcd_pkg::STAGES-1:0]    vpipe;

  function automatic logic [gcd_pkg::ANG_W-1:0] unit_clamp(
    input logic signed [gcd_pkg::CW-1:0] v);
    logic [gcd_pkg::ANG_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, gcd_pkg::Q30_ONE})) begin
      r = gcd_pkg::Q30_ONE;
    end else begin
      r = v[gcd_pkg::ANG_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [gcd_pkg::CW-1:0] xi, yi, zi;
    for (int s = 0; s < gcd_pkg::STAGES; s++) begin
      for (int l = 0; l < 4; l++) begin
        if (s == 0) begin
          xi = gcd_pkg::GAIN_INV_Q30;
          yi = '0;
          zi = $signed({3'b000, ang[l]});
        end else begin
          xi = xr[s-1][l];
          yi = yr[s-1][l];
          zi = zr[s-1][l];
        end
        if (zi >= 0) begin
          x_next[s][l] = xi - (yi >>> s);
          y_next[s][l] = yi + (xi >>> s);
          z_next[s][l] = zi - gcd_pkg::atan_q30(s);
        end else begin
          x_next[s][l] = xi + (yi >>> s);
          y_next[s][l] = yi - (xi >>> s);
          z_next[s][l] = zi + gcd_pkg::atan_q30(s);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr <= x_next;
      yr <= y_next;
      zr <= z_next;
      for (int l = 0; l < 4; l++) begin
        sin_q30[l] <= unit_clamp(yr[gcd_pkg::STAGES-1][l]);
        cos_q30[l] <= unit_clamp(xr[gcd_pkg::STAGES-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      valid_out <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[gcd_pkg::STAGES-2:0], valid_in};
      valid_out <= vpipe[gcd_pkg::STAGES-1];
    end
  end

endmodule

### design/gcd_sqrt.sv
// two-lane pipelined floor square root of a q30 value, one root digit per stage
module gcd_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic [gcd_pkg::ANG_W-1:0]    val_q30 [2],
  output logic                         valid_out,
  output logic [gcd_pkg::SQ_STEPS-1:0] root_q30 [2]
);

  logic [gcd_pkg::SQ_RAD_W-1:0] radr [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_REM_W-1:0] remr [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_STEPS-1:0] rootr [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_RAD_W-1:0] rad_next [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_REM_W-1:0] rem_next [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_STEPS-1:0] root_next [gcd_pkg::SQ_STEPS][2];
  logic [gcd_pkg::SQ_STEPS-1:0] vpipe;

  always_comb begin
    logic [gcd_pkg::SQ_RAD_W-1:0] rad_i;
    logic [gcd_pkg::SQ_REM_W-1:0] rem_i, rem2, trial;
    logic [gcd_pkg::SQ_STEPS-1:0] root_i;
    for (int s = 0; s < gcd_pkg::SQ_STEPS; s++) begin
      for (int l = 0; l < 2; l++) begin
        if (s == 0) begin
          // radicand is the value shifted up by 30
          rad_i  = {1'b0, val_q30[l], 30'b0};
          rem_i  = '0;
          root_i = '0;
        end else begin
          rad_i  = radr[s-1][l];
          rem_i  = remr[s-1][l];
          root_i = rootr[s-1][l];
        end
        rem2  = {rem_i[gcd_pkg::SQ_REM_W-3:0], rad_i[gcd_pkg::SQ_RAD_W-1 -: 2]};
        trial = {2'b00, root_i, 2'b01};
        if (rem2 >= trial) begin
          rem_next[s][l]  = rem2 - trial;
          root_next[s][l] = {root_i[gcd_pkg::SQ_STEPS-2:0], 1'b1};
        end else begin
          rem_next[s][l]  = rem2;
          root_next[s][l] = {root_i[gcd_pkg::SQ_STEPS-2:0], 1'b0};
        end
        rad_next[s][l] = {rad_i[gcd_pkg::SQ_RAD_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radr  <= rad_next;
      remr  <= rem_next;
      rootr <= root_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[gcd_pkg::SQ_STEPS-2:0], valid_in};
    end
  end

  assign root_q30[0] = rootr[gcd_pkg::SQ_STEPS-1][0];
  assign root_q30[1] = rootr[gcd_pkg::SQ_STEPS-1][1];
  assign valid_out   = vpipe[gcd_pkg::SQ_STEPS-1];

endmodule

### design/gcd_vec_cordic.sv
// pipelined vectoring-mode cordic giving atan2(y, x) in q30
module gcd_vec_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic [gcd_pkg::SQ_STEPS-1:0]  x_q30,
  input  logic [gcd_pkg::SQ_STEPS-1:0]  y_q30,
  output logic                          valid_out,
  output logic signed [gcd_pkg::CW-1:0] angle_q30
);

  logic signed [gcd_pkg::CW-1:0] xr [gcd_pkg::STAGES];
  logic signed [gcd_pkg::CW-1:0] yr [gcd_pkg::STAGES];
  logic signed [gcd_pkg::CW-1:0] zr [gcd_pkg::STAGES];
  logic signed [gcd_pkg::CW-1:0] x_next [gcd_pkg::STAGES];
  logic signed [gcd_pkg::CW-1:0] y_next [gcd_pkg::STAGES];
  logic signed [gcd_pkg::CW-1:0] z_next [gcd_pkg::STAGES];
  logic [gcd_pkg::STAGES-1:0]    vpipe;

  always_comb begin
    logic signed [gcd_pkg::CW-1:0] xi, yi, zi;
    for (int s = 0; s < gcd_pkg::STAGES; s++) begin
      if (s == 0) begin
        xi = $signed({3'b000, x_q30});
        yi = $signed({3'b000, y_q30});
        zi = '0;
      end else begin
        xi = xr[s-1];
        yi = yr[s-1];
        zi = zr[s-1];
      end
      if (yi >= 0) begin
        x_next[s] = xi + (yi >>> s);
        y_next[s] = yi - (xi >>> s);
        z_next[s] = zi + gcd_pkg::atan_q30(s);
      end else begin
        x_next[s] = xi - (yi >>> s);
        y_next[s] = yi + (xi >>> s);
        z_next[s] = zi - gcd_pkg::atan_q30(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr <= x_next;
      yr <= y_next;
      zr <= z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[gcd_pkg::STAGES-2:0], valid_in};
    end
  end

  assign angle_q30 = zr[gcd_pkg::STAGES-1];
  assign valid_out = vpipe[gcd_pkg::STAGES-1];

endmodule

### design/great_circle_distance.sv
// top level: pipelined haversine great-circle distance between two points
// throughput: one beat per cycle while no result beat is held; the pipeline is 107 register stages deep,
//   set by two 32-stage cordics, a 31-digit root and the clamp, multiply and scaling stages
// a result beat held by result_stall freezes the whole pipeline for that cycle
// reset clears every valid bit; data registers are not reset
module great_circle_distance (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [gcd_pkg::LAT_W-1:0]  first_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]  first_longitude,
  input  logic signed [gcd_pkg::LAT_W-1:0]  second_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]  second_longitude,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [gcd_pkg::DIST_W-1:0]        distance_km
);

  // global advance: everything moves unless the output beat is held
  logic en;

  // stage 1: clamped coordinates
  logic                             v1;
  logic signed [gcd_pkg::LAT_W-1:0] lat1c, lat2c;
  logic signed [gcd_pkg::LON_W-1:0] lon1c, lon2c;

  // stage 2: magnitudes of latitudes and of the differences
  logic        v2;
  logic [22:0] alat1, alat2;
  logic [23:0] adlat;
  logic [24:0] adlon;

  // stage 3: products with the degree-to-radian factor
  logic        v3;
  logic [47:0] p_lat1, p_lat2;
  logic [48:0] p_dlat;
  logic [49:0] p_dlon;

  // stage 4: rounded radians, clamped, longitude half-difference reflected
  logic                      v4;
  logic [gcd_pkg::ANG_W-1:0] ang [4];
  logic [gcd_pkg::ANG_W-1:0] ang_next [4];

  // sine / cosine unit
  logic                      rot_valid;
  logic [gcd_pkg::ANG_W-1:0] sin_q30 [4];
  logic [gcd_pkg::ANG_W-1:0] cos_q30 [4];

  // stages p1..p4: squares, products, the term a and 1 - a
  logic                      vp1, vp2, vp3, vp4;
  logic [gcd_pkg::ANG_W-1:0] slat2, slon2, cprod;
  logic [gcd_pkg::ANG_W-1:0] slat2_d, term2;
  logic [gcd_pkg::ANG_W:0]   asum;
  logic [gcd_pkg::ANG_W-1:0] sq_in [2];

  // roots and arctangent
  logic                          sq_valid;
  logic [gcd_pkg::SQ_STEPS-1:0]  roots [2];
  logic                          vec_valid;
  logic signed [gcd_pkg::CW-1:0] zang;

  // stages m1..m3: scale the central angle to kilometres
  logic        vm1, vm2;
  logic [31:0] zpos;
  logic [53:0] dprod;

  logic [61:0] mul_lat, mul_lon, mul_cos, mul_term;
  logic [54:0] dsum;

  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // ---- stage 1: clamp to +-90 and +-180 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      lat1c <= (first_latitude > gcd_pkg::LAT_MAX) ? gcd_pkg::LAT_MAX :
               (first_latitude < gcd_pkg::LAT_MIN) ? gcd_pkg::LAT_MIN : first_latitude;
      lat2c <= (second_latitude > gcd_pkg::LAT_MAX) ? gcd_pkg::LAT_MAX :
               (second_latitude < gcd_pkg::LAT_MIN) ? gcd_pkg::LAT_MIN : second_latitude;
      lon1c <= (first_longitude > gcd_pkg::LON_MAX) ? gcd_pkg::LON_MAX :
               (first_longitude < gcd_pkg::LON_MIN) ? gcd_pkg::LON_MIN : first_longitude;
      lon2c <= (second_longitude > gcd_pkg::LON_MAX) ? gcd_pkg::LON_MAX :
               (second_longitude < gcd_pkg::LON_MIN) ? gcd_pkg::LON_MIN : second_longitude;
    end
  end

  // ---- stage 2: absolute values; sin^2 and cos are even so signs drop out
  always_ff @(posedge clk) begin
    logic signed [24:0] dlat;
    logic signed [25:0] dlon;
    logic signed [23:0] m1, m2;
    logic signed [24:0] mdlat;
    logic signed [25:0] mdlon;
    if (en) begin
      dlat  = {lat2c[gcd_pkg::LAT_W-1], lat2c} - {lat1c[gcd_pkg::LAT_W-1], lat1c};
      dlon  = {lon2c[gcd_pkg::LON_W-1], lon2c} - {lon1c[gcd_pkg::LON_W-1], lon1c};
      m1    = (lat1c < 0) ? -lat1c : lat1c;
      m2    = (lat2c < 0) ? -lat2c : lat2c;
      mdlat = (dlat < 0) ? -dlat : dlat;
      mdlon = (dlon < 0) ? -dlon : dlon;
      alat1 <= m1[22:0];
      alat2 <= m2[22:0];
      adlat <= mdlat[23:0];
      adlon <= mdlon[24:0];
    end
  end

  // ---- stage 3: one 25-bit multiply per angle
  always_ff @(posedge clk) begin
    if (en) begin
      p_lat1 <= {25'b0, alat1} * {23'b0, gcd_pkg::DEG2RAD_Q30};
      p_lat2 <= {25'b0, alat2} * {23'b0, gcd_pkg::DEG2RAD_Q30};
      p_dlat <= {25'b0, adlat} * {24'b0, gcd_pkg::DEG2RAD_Q30};
      p_dlon <= {25'b0, adlon} * {25'b0, gcd_pkg::DEG2RAD_Q30};
    end
  end

  // ---- stage 4: round half up to q30, clamp to the cordic range
  always_comb begin
    logic [47:0] s1, s2;
    logic [48:0] sdl;
    logic [49:0] sdn;
    logic [32:0] hlon;
    logic [32:0] hlon_c;
    s1  = p_lat1 + 48'd32768;
    s2  = p_lat2 + 48'd32768;
    sdl = p_dlat + 49'd65536;
    sdn = p_dlon + 50'd65536;
    ang_next[0] = (s1[47:16] > gcd_pkg::HALF_PI_Q30) ?
                  gcd_pkg::HALF_PI_Q30[gcd_pkg::ANG_W-1:0] : s1[46:16];
    ang_next[1] = (s2[47:16] > gcd_pkg::HALF_PI_Q30) ?
                  gcd_pkg::HALF_PI_Q30[gcd_pkg::ANG_W-1:0] : s2[46:16];
    ang_next[2] = (sdl[48:17] > gcd_pkg::HALF_PI_Q30) ?
                  gcd_pkg::HALF_PI_Q30[gcd_pkg::ANG_W-1:0] : sdl[47:17];
    hlon   = sdn[49:17];
    hlon_c = (hlon > gcd_pkg::PI_Q30) ? gcd_pkg::PI_Q30 : hlon;
    // half longitude difference past pi/2 folds back as pi - h
    if (hlon_c > {1'b0, gcd_pkg::HALF_PI_Q30}) begin
      hlon_c = gcd_pkg::PI_Q30 - hlon_c;
    end
    ang_next[3] = hlon_c[gcd_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= ang_next;
    end
  end

  // lanes: cos(lat1), cos(lat2), sin(dlat/2), sin(dlon/2)
  gcd_rot_cordic u_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (v4),
    .ang       (ang),
    .valid_out (rot_valid),
    .sin_q30   (sin_q30),
    .cos_q30   (cos_q30)
  );

  // ---- p1: squares of the half-difference sines and cos1 * cos2
  assign mul_lat  = {31'b0, sin_q30[2]} * {31'b0, sin_q30[2]};
  assign mul_lon  = {31'b0, sin_q30[3]} * {31'b0, sin_q30[3]};
  assign mul_cos  = {31'b0, cos_q30[0]} * {31'b0, cos_q30[1]};
  // ---- p2: cos product times sin^2(dlon/2)
  assign mul_term = {31'b0, cprod} * {31'b0, slon2};

  always_ff @(posedge clk) begin
    if (en) begin
      slat2   <= mul_lat[60:30];
      slon2   <= mul_lon[60:30];
      cprod   <= mul_cos[60:30];
      slat2_d <= slat2;
      term2   <= mul_term[60:30];
      asum    <= {1'b0, slat2_d} + {1'b0, term2};
      // ---- p4: clamp a to one, then take its complement
      sq_in[0] <= (asum > {1'b0, gcd_pkg::Q30_ONE}) ? gcd_pkg::Q30_ONE
                                                   : asum[gcd_pkg::ANG_W-1:0];
      sq_in[1] <= (asum > {1'b0, gcd_pkg::Q30_ONE}) ? '0
                                                   : gcd_pkg::Q30_ONE - asum[gcd_pkg::ANG_W-1:0];
    end
  end

  // lane 0: sqrt(a), lane 1: sqrt(1 - a)
  gcd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (vp4),
    .val_q30   (sq_in),
    .valid_out (sq_valid),
    .root_q30  (roots)
  );

  gcd_vec_cordic u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (sq_valid),
    .x_q30     (roots[1]),
    .y_q30     (roots[0]),
    .valid_out (vec_valid),
    .angle_q30 (zang)
  );

  // ---- m1..m3: clamp at zero, times 2R in q8, round half up, saturate
  assign dsum = {1'b0, dprod} + 55'd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      zpos  <= (zang < 0) ? '0 : zang[31:0];
      dprod <= {22'b0, zpos} * {32'b0, gcd_pkg::TWO_R_Q8};
      distance_km <= (dsum[54:30] > {2'b00, gcd_pkg::HALF_CIRC_Q8}) ?
                     gcd_pkg::HALF_CIRC_Q8 : dsum[52:30];
    end
  end

  // valid bits ride alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      vp1          <= 1'b0;
      vp2          <= 1'b0;
      vp3          <= 1'b0;
      vp4          <= 1'b0;
      vm1          <= 1'b0;
      vm2          <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      vp1          <= rot_valid;
      vp2          <= vp1;
      vp3          <= vp2;
      vp4          <= vp3;
      vm1          <= vec_valid;
      vm2          <= vm1;
      result_valid <= vm2;
    end
  end

endmodule

### design/gcd_checker.sv
// port-level checker for the great-circle distance block, bound to the top level
`include "great_circle_distance_defines.svh"

module gcd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [gcd_pkg::DIST_W-1:0] distance_km
);

  // distance never passes half the circumference
  `GCD_ASSERT_SAME(dist_capped, result_valid, distance_km <= gcd_pkg::HALF_CIRC_Q8)

  // a held result freezes intake
  `GCD_ASSERT_SAME(hold_stalls_input, result_valid && result_stall, item_stall)

  // with no result waiting the input side is always open
  `GCD_ASSERT_SAME(empty_out_open, !result_valid, !item_stall)

  // a held result stays put
  `GCD_ASSERT_NEXT(held_result_stable, result_valid && result_stall,
                   result_valid && $stable(distance_km))

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);

### tb/great_circle_distance_checker.sv
// distance predictor and result scoreboard for the great-circle distance block
`timescale 1ns / 1ps
module great_circle_distance_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic signed [gcd_pkg::LAT_W-1:0]  first_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]  first_longitude,
  input  logic signed [gcd_pkg::LAT_W-1:0]  second_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]  second_longitude,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic [gcd_pkg::DIST_W-1:0]        distance_km,
  output int                                fail_count,
  output int                                pending
);

  // ring of predicted distances, far deeper than the pipeline
  localparam int EXP_DEPTH = 4096;

  logic [gcd_pkg::DIST_W-1:0] expected_distances [EXP_DEPTH];
  int                         wr_count;
  int                         rd_count;
  logic [11:0]                wr_slot;
  logic [11:0]                rd_slot;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, bit_pos;
    r = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos >>= 2;
    while (bit_pos != 0) begin
      if (v >= r + bit_pos) begin
        v -= r + bit_pos;
        r = (r >> 1) + bit_pos;
      end else begin
        r >>= 1;
      end
      bit_pos >>= 2;
    end
    return r;
  endfunction

  // rotation cordic, returns clamped sine
  function automatic longint rot_sin(longint ang, output longint cosv);
    longint x, y, z, nx;
    x = gcd_pkg::GAIN_INV_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < gcd_pkg::STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i);
        z -= gcd_pkg::atan_q30(i);
      end else begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i);
        z += gcd_pkg::atan_q30(i);
      end
      x = nx;
    end
    cosv = sat(x, 0, 64'd1 << 30);
    return sat(y, 0, 64'd1 << 30);
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z, nx;
    z = 0;
    for (int i = 0; i < gcd_pkg::STAGES; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i);
        z += gcd_pkg::atan_q30(i);
      end else begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i);
        z -= gcd_pkg::atan_q30(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] haversine_km(longint la1, longint lo1,
                                                              longint la2, longint lo2);
    longint one, r1, r2, hlat, hlon, s, c, cos1, cos2, slat2, slon2, t, a, z, d;
    one = 64'd1 << 30;
    la1 = sat(la1, gcd_pkg::LAT_MIN, gcd_pkg::LAT_MAX);
    la2 = sat(la2, gcd_pkg::LAT_MIN, gcd_pkg::LAT_MAX);
    lo1 = sat(lo1, gcd_pkg::LON_MIN, gcd_pkg::LON_MAX);
    lo2 = sat(lo2, gcd_pkg::LON_MIN, gcd_pkg::LON_MAX);
    r1 = ((la1 < 0 ? -la1 : la1) * gcd_pkg::DEG2RAD_Q30 + (1 << 15)) >> 16;
    r2 = ((la2 < 0 ? -la2 : la2) * gcd_pkg::DEG2RAD_Q30 + (1 << 15)) >> 16;
    hlat = (((la2 > la1) ? la2 - la1 : la1 - la2) * gcd_pkg::DEG2RAD_Q30
            + (1 << 16)) >> 17;
    hlon = (((lo2 > lo1) ? lo2 - lo1 : lo1 - lo2) * gcd_pkg::DEG2RAD_Q30
            + (1 << 16)) >> 17;
    if (r1 > gcd_pkg::HALF_PI_Q30) r1 = gcd_pkg::HALF_PI_Q30;
    if (r2 > gcd_pkg::HALF_PI_Q30) r2 = gcd_pkg::HALF_PI_Q30;
    if (hlat > gcd_pkg::HALF_PI_Q30) hlat = gcd_pkg::HALF_PI_Q30;
    if (hlon > gcd_pkg::PI_Q30) hlon = gcd_pkg::PI_Q30;
    if (hlon > gcd_pkg::HALF_PI_Q30) hlon = gcd_pkg::PI_Q30 - hlon;
    s = rot_sin(r1, cos1);
    s = rot_sin(r2, cos2);
    s = rot_sin(hlat, c);
    slat2 = (s * s) >> 30;
    s = rot_sin(hlon, c);
    slon2 = (s * s) >> 30;
    t = (cos1 * cos2) >> 30;
    a = slat2 + ((t * slon2) >> 30);
    if (a > one) a = one;
    z = vec_angle(root_floor((one - a) << 30), root_floor(a << 30));
    if (z < 0) z = 0;
    d = (z * gcd_pkg::TWO_R_Q8 + (64'd1 << 29)) >> 30;
    if (d > gcd_pkg::HALF_CIRC_Q8) d = gcd_pkg::HALF_CIRC_Q8;
    return d[gcd_pkg::DIST_W-1:0];
  endfunction

  assign wr_slot = wr_count[11:0];
  assign rd_slot = rd_count[11:0];
  assign pending = wr_count - rd_count;

  always @(posedge clk) begin
    logic [gcd_pkg::DIST_W-1:0] want;
    if (rst) begin
      fail_count <= 0;
      wr_count   <= 0;
      rd_count   <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_distances[wr_slot] <= haversine_km(first_latitude, first_longitude,
                                                    second_latitude, second_longitude);
        wr_count <= wr_count + 1;
      end
      if (result_valid && !result_stall) begin
        if (wr_count == rd_count) begin
          $error("distance_km beat with nothing expected: %0d", distance_km);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_distances[rd_slot];
          rd_count <= rd_count + 1;
          if (want !== distance_km) begin
            $error("distance_km expected %0d actual %0d", want, distance_km);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### tb/great_circle_distance_tb.sv
// stimulus and verdict for the great-circle distance block
`timescale 1ns / 1ps
module great_circle_distance_tb;

  localparam int N_RANDOM = 1800;
  localparam int DRAIN_CYCLES = 250;  // beyond the 107-stage pipeline
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [gcd_pkg::LAT_W-1:0] first_latitude = '0;
  logic signed [gcd_pkg::LON_W-1:0] first_longitude = '0;
  logic signed [gcd_pkg::LAT_W-1:0] second_latitude = '0;
  logic signed [gcd_pkg::LON_W-1:0] second_longitude = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [gcd_pkg::DIST_W-1:0] distance_km;
  int fail_count;
  int pending;
  int phase_left = 0;
  longint cycle_count = 0;

  always #6 clk = ~clk;

  great_circle_distance i_dut (.*);

  great_circle_distance_checker i_checker (.*);

  // mostly short gaps, now and then a long one, and stretches of none
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receiver stall in runs: mostly open, short holds, a few long holds
  always @(posedge clk) begin
    int p;
    if (rst) begin
      result_stall <= 1'b0;
      phase_left   <= 0;
    end else if (phase_left != 0) begin
      phase_left <= phase_left - 1;
    end else begin
      p = $urandom_range(99);
      if (p < 80) begin
        result_stall <= 1'b0;
        phase_left   <= $urandom_range(5, 0);
      end else if (p < 98) begin
        result_stall <= 1'b1;
        phase_left   <= $urandom_range(2, 0);
      end else begin
        result_stall <= 1'b1;
        phase_left   <= $urandom_range(39, 9);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("great_circle_distance_tb NOT OK");
      $finish;
    end
  end

  // one beat, held until accepted, then optional idle cycles
  task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2);
    int g;
    item_valid <= 1'b1;
    first_latitude <= la1[gcd_pkg::LAT_W-1:0];
    first_longitude <= lo1[gcd_pkg::LON_W-1:0];
    second_latitude <= la2[gcd_pkg::LAT_W-1:0];
    second_longitude <= lo2[gcd_pkg::LON_W-1:0];
    @(posedge clk);
    while (item_stall) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic longint rnd_lat();
    int p;
    p = $urandom_range(99);
    if (p < 5) return $signed($urandom()) >>> 8;  // full 24-bit span, often clamped
    return longint'($urandom_range(11796480)) - 5898240;
  endfunction

  function automatic longint rnd_lon();
    int p;
    p = $urandom_range(99);
    if (p < 5) return $signed($urandom()) >>> 7;
    return longint'($urandom_range(23592960)) - 11796480;
  endfunction

  initial begin
    longint la, lo;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: coincident, poles, antipodes, range ends, clamping, bit extremes
    send_pair(0, 0, 0, 0);
    send_pair(gcd_pkg::LAT_MAX, 0, gcd_pkg::LAT_MIN, 0);
    send_pair(0, gcd_pkg::LON_MIN, 0, gcd_pkg::LON_MAX);
    send_pair(0, 0, 0, gcd_pkg::LON_MAX);
    send_pair(0, 0, 0, gcd_pkg::LON_MIN);
    send_pair(gcd_pkg::LAT_MAX, gcd_pkg::LON_MAX, gcd_pkg::LAT_MAX, gcd_pkg::LON_MIN);
    send_pair(gcd_pkg::LAT_MIN, gcd_pkg::LON_MIN, gcd_pkg::LAT_MAX, gcd_pkg::LON_MAX);
    send_pair(24'sh7FFFFF, 25'sh0FFFFFF, -24'sh800000, -25'sh1000000);
    send_pair(-24'sh800000, -25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
    send_pair(-1, -1, -1, -1);
    send_pair(-1, -1, 1, 1);
    send_pair(1, 0, 0, 0);
    send_pair(0, 0, 0, 1);
    send_pair(2949120, 5898240, -2949120, -5898240);
    send_pair(0, 0, 0, 11796479);
    send_pair(3276800, 983040, 3276801, 983040);
    send_pair(gcd_pkg::LAT_MAX + 1, gcd_pkg::LON_MAX + 1,
              gcd_pkg::LAT_MIN - 1, gcd_pkg::LON_MIN - 1);
    send_pair(-2949120, 11796480, 2949120, -11796480);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(9))
        0: begin  // near-coincident pair
          la = rnd_lat(); lo = rnd_lon();
          send_pair(la, lo, la + $signed($urandom_range(64)) - 32,
                    lo + $signed($urandom_range(64)) - 32);
        end
        1: begin  // near-antipodal pair
          la = rnd_lat(); lo = rnd_lon();
          send_pair(la, lo, -la + $urandom_range(200) - 100,
                    (lo > 0 ? lo - 11796480 : lo + 11796480) + $urandom_range(200) - 100);
        end
        default: send_pair(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon());
      endcase
    end
    item_valid <= 1'b0;
    // let the last accepted beat reach the scoreboard before polling it
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("great_circle_distance_tb OK");
    else $display("great_circle_distance_tb NOT OK");
    $finish;
  end
endmodule
